// ===== design/irbt_pkg.sv =====
// ----------------------------------------------------------------------------
// irbt_pkg
// Shared types and constants for the infrared byte transceiver (8E1 frame).
// ----------------------------------------------------------------------------
package irbt_pkg;

  localparam int CFG_WIDTH  = 16;
  localparam int BYTE_WIDTH = 8;

  localparam logic [15:0] BIT_TICKS_RST   = 16'd1000;
  localparam logic [15:0] START_DELAY_RST = 16'd500;

  localparam logic [3:0] FRAME_BITS = 4'd12;
  localparam logic [3:0] RX_BITS    = 4'd10;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_SEND        = 3'd1,
    REQ_TAKE        = 3'd2,
    REQ_CARRIER_ON  = 3'd3,
    REQ_CARRIER_OFF = 3'd4
  } req_t;

  typedef enum logic {
    CFG_BIT_TICKS   = 1'b0,
    CFG_START_DELAY = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RX_HUNT   = 2'd0,
    RX_DELAY  = 2'd1,
    RX_SAMPLE = 2'd2
  } rx_mode_t;

  typedef struct packed {
    logic                  step;
    logic                  send;
    logic                  carrier_set;
    logic                  carrier_val;
    logic [BYTE_WIDTH-1:0] data;
  } tx_ctrl_t;

  typedef struct packed {
    logic active;
    logic active_nxt;
    logic line_nxt;
    logic steady_nxt;
  } tx_stat_t;

  typedef struct packed {
    logic step;
    logic take;
    logic steady;
    logic level;
  } rx_ctrl_t;

  typedef struct packed {
    logic                  idle;
    logic                  busy_nxt;
    logic                  valid_nxt;
    logic                  frame_err;
    logic [BYTE_WIDTH-1:0] byte_out;
  } rx_stat_t;

endpackage

// ===== design/ir_byte_transceiver_even_parity_top.sv =====
// ----------------------------------------------------------------------------
// ir_byte_transceiver_even_parity_top
// Infrared byte transceiver with an 8E1 frame, stepped once per timer tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel is one timer tick carrying a request code,
//   a byte to send and the receiver pin level. Each request gives exactly one
//   result on the out_ channel with the line drive, busy flags, the held
//   received byte, the accept flag, a frame error pulse and the carrier sense.
//   A request is registered at the input, decoded against the transmit and
//   receive state in one pass, and the result is registered: a request passes
//   the input register and then the result register before out_valid shows
//   its result, and one request per cycle is taken while out_stall stays low.
//   When out_stall is high the result holds and one more request is taken
//   into the input register; after that in_stall rises until the result is
//   taken.
//   cfg_we writes bit_ticks (index 0) or start_delay_ticks (index 1); write
//   only while no request is in flight.
//   Reset (rst_n low, synchronous) empties both registers, sets the line low,
//   ends any frame, drops the held byte and restores bit_ticks to 1000 and
//   start_delay_ticks to 500.
// ----------------------------------------------------------------------------
module ir_byte_transceiver_even_parity_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_rx_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_drive,
  output logic        out_tx_busy,
  output logic        out_rx_busy,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_accepted,
  output logic        out_frame_error,
  output logic        out_carrier_sensed
);

  logic [15:0] bit_ticks_r, start_delay_r;

  logic                in_valid_r;
  irbt_pkg::req_t      req_r;
  logic [7:0]          tx_byte_r;
  logic                rx_level_r;

  logic                out_valid_r;
  logic                tx_drive_r, tx_busy_r, rx_busy_r, rx_valid_r;
  logic [7:0]          rx_byte_r;
  logic                accepted_r, frame_error_r, carrier_sensed_r;

  logic                advance;
  logic                acc;
  irbt_pkg::tx_ctrl_t  tx_ctrl;
  irbt_pkg::tx_stat_t  tx_stat;
  irbt_pkg::rx_ctrl_t  rx_ctrl;
  irbt_pkg::rx_stat_t  rx_stat;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r   <= irbt_pkg::BIT_TICKS_RST;
      start_delay_r <= irbt_pkg::START_DELAY_RST;
    end else if (cfg_we) begin
      case (irbt_pkg::cfg_idx_t'(cfg_index))
        irbt_pkg::CFG_BIT_TICKS:   bit_ticks_r   <= cfg_data;
        irbt_pkg::CFG_START_DELAY: start_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r      <= irbt_pkg::req_t'(in_req_type);
      tx_byte_r  <= in_tx_byte;
      rx_level_r <= in_rx_level;
    end
  end

  // request decode
  always_comb begin
    acc                 = 1'b0;
    tx_ctrl.step        = advance;
    tx_ctrl.send        = 1'b0;
    tx_ctrl.carrier_set = 1'b0;
    tx_ctrl.carrier_val = (req_r == irbt_pkg::REQ_CARRIER_ON);
    tx_ctrl.data        = tx_byte_r;
    rx_ctrl.step        = advance;
    rx_ctrl.take        = 1'b0;
    rx_ctrl.level       = rx_level_r;
    case (req_r)
      irbt_pkg::REQ_TICK: begin
        acc = 1'b1;
      end
      irbt_pkg::REQ_SEND: begin
        acc          = !tx_stat.active;
        tx_ctrl.send = !tx_stat.active;
      end
      irbt_pkg::REQ_TAKE: begin
        acc          = rx_stat.idle;
        rx_ctrl.take = rx_stat.idle;
      end
      irbt_pkg::REQ_CARRIER_ON, irbt_pkg::REQ_CARRIER_OFF: begin
        acc                 = !tx_stat.active && rx_stat.idle;
        tx_ctrl.carrier_set = !tx_stat.active && rx_stat.idle;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
    rx_ctrl.steady = tx_stat.steady_nxt;
  end

  irbt_tx #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tx_ctrl),
    .bit_ticks (bit_ticks_r),
    .stat      (tx_stat)
  );

  irbt_rx #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (rx_ctrl),
    .bit_ticks   (bit_ticks_r),
    .start_delay (start_delay_r),
    .stat        (rx_stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_drive_r       <= tx_stat.line_nxt;
      tx_busy_r        <= tx_stat.active_nxt;
      rx_busy_r        <= rx_stat.busy_nxt;
      rx_valid_r       <= rx_stat.valid_nxt;
      rx_byte_r        <= rx_stat.byte_out;
      accepted_r       <= acc;
      frame_error_r    <= rx_stat.frame_err;
      carrier_sensed_r <= !rx_level_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_drive       = tx_drive_r;
  assign out_tx_busy        = tx_busy_r;
  assign out_rx_busy        = rx_busy_r;
  assign out_rx_valid       = rx_valid_r;
  assign out_rx_byte        = rx_byte_r;
  assign out_accepted       = accepted_r;
  assign out_frame_error    = frame_error_r;
  assign out_carrier_sensed = carrier_sensed_r;

endmodule

// ===== design/irbt_tx.sv =====
// ----------------------------------------------------------------------------
// irbt_tx
// Transmit side: frame shifter, bit timer, line level and steady carrier.
// ----------------------------------------------------------------------------
module irbt_tx #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irbt_pkg::tx_ctrl_t            ctrl,
  input  logic [irbt_pkg::CFG_WIDTH-1:0] bit_ticks,
  output irbt_pkg::tx_stat_t            stat
);

  localparam int CW = (TIMER_WIDTH > irbt_pkg::CFG_WIDTH) ? TIMER_WIDTH : irbt_pkg::CFG_WIDTH;

  logic [11:0]            shift_r, shift_nxt;
  logic [3:0]             count_r, count_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic                   active_r, active_nxt;
  logic                   line_r, line_nxt;
  logic                   steady_r, steady_nxt;

  logic [TIMER_WIDTH-1:0]        timer_inc;
  logic [3:0]                    count_inc;
  logic [irbt_pkg::CFG_WIDTH-1:0] period;

  always_comb begin
    shift_nxt  = shift_r;
    count_nxt  = count_r;
    timer_nxt  = timer_r;
    active_nxt = active_r;
    line_nxt   = line_r;
    steady_nxt = steady_r;
    period     = (bit_ticks == '0) ? irbt_pkg::CFG_WIDTH'(1) : bit_ticks;

    // request first
    if (ctrl.send) begin
      steady_nxt = 1'b0;
      line_nxt   = 1'b0;
      shift_nxt  = {1'b0, 1'b1, ^ctrl.data, ctrl.data, 1'b1};
      count_nxt  = '0;
      timer_nxt  = '0;
      active_nxt = 1'b1;
    end
    if (ctrl.carrier_set) begin
      steady_nxt = ctrl.carrier_val;
      line_nxt   = ctrl.carrier_val;
    end

    // bit timer
    timer_inc = timer_nxt + TIMER_WIDTH'(1);
    count_inc = count_nxt + 4'd1;
    if (active_nxt) begin
      timer_nxt = timer_inc;
      if (CW'(timer_inc) >= CW'(period)) begin
        timer_nxt = '0;
        line_nxt  = shift_nxt[0];
        shift_nxt = {1'b0, shift_nxt[11:1]};
        count_nxt = count_inc;
        if (count_inc >= irbt_pkg::FRAME_BITS) begin
          active_nxt = 1'b0;
        end
      end
    end

    stat.active     = active_r;
    stat.active_nxt = active_nxt;
    stat.line_nxt   = line_nxt;
    stat.steady_nxt = steady_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      count_r  <= '0;
      timer_r  <= '0;
      active_r <= 1'b0;
      line_r   <= 1'b0;
      steady_r <= 1'b0;
    end else if (ctrl.step) begin
      shift_r  <= shift_nxt;
      count_r  <= count_nxt;
      timer_r  <= timer_nxt;
      active_r <= active_nxt;
      line_r   <= line_nxt;
      steady_r <= steady_nxt;
    end
  end

endmodule

// ===== design/irbt_rx.sv =====
// ----------------------------------------------------------------------------
// irbt_rx
// Receive side: start edge hunt, start delay, ten samples, parity and stop check.
// ----------------------------------------------------------------------------
module irbt_rx #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irbt_pkg::rx_ctrl_t            ctrl,
  input  logic [irbt_pkg::CFG_WIDTH-1:0] bit_ticks,
  input  logic [irbt_pkg::CFG_WIDTH-1:0] start_delay,
  output irbt_pkg::rx_stat_t            stat
);

  localparam int CW = (TIMER_WIDTH > irbt_pkg::CFG_WIDTH) ? TIMER_WIDTH : irbt_pkg::CFG_WIDTH;

  irbt_pkg::rx_mode_t mode_r, mode_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [3:0]             count_r, count_nxt;
  logic [9:0]             shift_r, shift_nxt;
  logic [7:0]             hold_r, hold_nxt;
  logic                   valid_r, valid_nxt;
  logic                   prev_r;
  logic                   ferr;

  logic [TIMER_WIDTH-1:0]        timer_inc;
  logic [3:0]                    count_inc;
  logic [9:0]                    sample_bit;
  logic [irbt_pkg::CFG_WIDTH-1:0] period;

  always_comb begin
    mode_nxt   = mode_r;
    timer_nxt  = timer_r;
    count_nxt  = count_r;
    shift_nxt  = shift_r;
    hold_nxt   = hold_r;
    valid_nxt  = ctrl.take ? 1'b0 : valid_r;
    ferr       = 1'b0;
    period     = (bit_ticks == '0) ? irbt_pkg::CFG_WIDTH'(1) : bit_ticks;
    timer_inc  = timer_r + TIMER_WIDTH'(1);
    count_inc  = count_r + 4'd1;
    sample_bit = 10'(!ctrl.level) << count_r;

    case (mode_r)
      irbt_pkg::RX_HUNT: begin
        if (!valid_nxt && !ctrl.steady && prev_r && !ctrl.level) begin
          count_nxt = '0;
          shift_nxt = '0;
          timer_nxt = '0;
          mode_nxt  = (start_delay == '0) ? irbt_pkg::RX_SAMPLE : irbt_pkg::RX_DELAY;
        end
      end
      irbt_pkg::RX_DELAY: begin
        timer_nxt = timer_inc;
        if (CW'(timer_inc) >= CW'(start_delay)) begin
          mode_nxt  = irbt_pkg::RX_SAMPLE;
          timer_nxt = '0;
        end
      end
      irbt_pkg::RX_SAMPLE: begin
        timer_nxt = timer_inc;
        if (CW'(timer_inc) >= CW'(period)) begin
          timer_nxt = '0;
          shift_nxt = shift_r | sample_bit;
          count_nxt = count_inc;
          if (count_inc >= irbt_pkg::RX_BITS) begin
            mode_nxt = irbt_pkg::RX_HUNT;
            if ((shift_nxt[8] == ^shift_nxt[7:0]) && shift_nxt[9]) begin
              hold_nxt  = shift_nxt[7:0];
              valid_nxt = 1'b1;
            end else begin
              ferr = 1'b1;
            end
          end
        end
      end
      default: begin
        mode_nxt = irbt_pkg::RX_HUNT;
      end
    endcase

    stat.idle      = (mode_r == irbt_pkg::RX_HUNT);
    stat.busy_nxt  = (mode_nxt != irbt_pkg::RX_HUNT);
    stat.valid_nxt = valid_nxt;
    stat.frame_err = ferr;
    if (ctrl.take) begin
      stat.byte_out = valid_r ? hold_r : '0;
    end else begin
      stat.byte_out = valid_nxt ? hold_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= irbt_pkg::RX_HUNT;
      timer_r <= '0;
      count_r <= '0;
      shift_r <= '0;
      hold_r  <= '0;
      valid_r <= 1'b0;
      prev_r  <= 1'b1;
    end else if (ctrl.step) begin
      mode_r  <= mode_nxt;
      timer_r <= timer_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      hold_r  <= hold_nxt;
      valid_r <= valid_nxt;
      prev_r  <= ctrl.level;
    end
  end

endmodule

// ===== design/irbt_checker.sv =====
// ----------------------------------------------------------------------------
// irbt_checker
// Port-level checks for the infrared byte transceiver, bound to the top level.
// ----------------------------------------------------------------------------
module irbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_rx_busy,
  input logic       out_rx_valid,
  input logic [7:0] out_rx_byte,
  input logic       out_frame_error
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rx_byte))
    else $error("result changed while stalled");

  // a bad frame ends reception and never leaves a byte held
  a_ferr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> !out_rx_valid && !out_rx_busy)
    else $error("frame error with byte held or receiver busy");

  // reception only starts with no byte held
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_busy |-> !out_rx_valid)
    else $error("receiving while a byte is held");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ir_byte_transceiver_even_parity_top irbt_checker u_irbt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rx_busy     (out_rx_busy),
  .out_rx_valid    (out_rx_valid),
  .out_rx_byte     (out_rx_byte),
  .out_frame_error (out_frame_error)
);

// ===== bench/ir_byte_transceiver_even_parity_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_byte_transceiver_even_parity_top_tb
// Self-checking bench for the infrared 8E1 byte transceiver. A queue of tick
// requests feeds a clocked driver; each accepted request steps a behavioral
// copy of the transceiver, whose status is compared field by field with the
// result the block returns. Receive waveforms are built as frames with random
// bytes, bad parity and bad stop marks, mixed with noise and random requests,
// across several timer settings and with random idling and stalls.
// ----------------------------------------------------------------------------
module ir_byte_transceiver_even_parity_top_tb;

  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] data;
    logic       level;
  } tick_t;

  typedef struct packed {
    logic       tx_drive;
    logic       tx_busy;
    logic       rx_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       accepted;
    logic       frame_error;
    logic       carrier_sensed;
  } status_t;

  typedef struct {
    logic               prev_level;
    irbt_pkg::rx_mode_t rx_mode;
    logic [15:0]        rx_timer;
    logic [3:0]         rx_bits;
    logic [9:0]         rx_shift;
    logic [7:0]         rx_hold;
    logic               rx_full;
    logic [11:0]        tx_shift;
    logic [3:0]         tx_bits;
    logic [15:0]        tx_timer;
    logic               tx_active;
    logic               line;
    logic               steady;
  } xcvr_state_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_index   = 1'b0;
  logic [15:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_tx_byte  = '0;
  logic        in_rx_level = 1'b1;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        out_tx_drive;
  logic        out_tx_busy;
  logic        out_rx_busy;
  logic        out_rx_valid;
  logic [7:0]  out_rx_byte;
  logic        out_accepted;
  logic        out_frame_error;
  logic        out_carrier_sensed;

  ir_byte_transceiver_even_parity_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_tx_byte         (in_tx_byte),
    .in_rx_level        (in_rx_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_tx_drive       (out_tx_drive),
    .out_tx_busy        (out_tx_busy),
    .out_rx_busy        (out_rx_busy),
    .out_rx_valid       (out_rx_valid),
    .out_rx_byte        (out_rx_byte),
    .out_accepted       (out_accepted),
    .out_frame_error    (out_frame_error),
    .out_carrier_sensed (out_carrier_sensed)
  );

  tick_t       pending_ticks[$];
  status_t     expected_status[$];
  xcvr_state_t xs;
  logic [15:0] bit_ticks_q;
  logic [15:0] start_delay_q;
  int          frame_ticks;
  int          frame_delay;
  int          ticks_added;
  int          send_gap_pct;
  int          stall_pct;
  int          errors;
  logic        hold_kick;
  logic        hold_seen;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // behavioral transceiver: request, then transmit timer, then receiver
  task automatic advance_transceiver(input logic [2:0] req, input logic [7:0] data,
                                     input logic level);
    status_t     st;
    logic        rx_idle;
    logic        took;
    logic [7:0]  taken;
    logic [7:0]  rx_data;
    logic [16:0] per;
    per     = (bit_ticks_q == 16'd0) ? 17'd1 : {1'b0, bit_ticks_q};
    rx_idle = (xs.rx_mode == irbt_pkg::RX_HUNT);
    st      = '0;
    took    = 1'b0;
    taken   = 8'h00;
    case (req)
      irbt_pkg::REQ_TICK: st.accepted = 1'b1;
      irbt_pkg::REQ_SEND: if (!xs.tx_active) begin
        st.accepted  = 1'b1;
        xs.steady    = 1'b0;
        xs.line      = 1'b0;
        xs.tx_shift  = {1'b0, 1'b1, ^data, data, 1'b1};
        xs.tx_bits   = '0;
        xs.tx_timer  = '0;
        xs.tx_active = 1'b1;
      end
      irbt_pkg::REQ_TAKE: if (rx_idle) begin
        st.accepted = 1'b1;
        took        = 1'b1;
        taken       = xs.rx_full ? xs.rx_hold : 8'h00;
        xs.rx_full  = 1'b0;
      end
      irbt_pkg::REQ_CARRIER_ON, irbt_pkg::REQ_CARRIER_OFF: if (!xs.tx_active && rx_idle) begin
        st.accepted = 1'b1;
        xs.steady   = (req == irbt_pkg::REQ_CARRIER_ON);
        xs.line     = xs.steady;
      end
      default: ;
    endcase

    if (xs.tx_active) begin
      xs.tx_timer = xs.tx_timer + 16'd1;
      if ({1'b0, xs.tx_timer} >= per) begin
        xs.tx_timer = '0;
        xs.line     = xs.tx_shift[0];
        xs.tx_shift = xs.tx_shift >> 1;
        xs.tx_bits  = xs.tx_bits + 4'd1;
        if (xs.tx_bits >= irbt_pkg::FRAME_BITS) xs.tx_active = 1'b0;
      end
    end

    case (xs.rx_mode)
      irbt_pkg::RX_DELAY: begin
        xs.rx_timer = xs.rx_timer + 16'd1;
        if (xs.rx_timer >= start_delay_q) begin
          xs.rx_mode  = irbt_pkg::RX_SAMPLE;
          xs.rx_timer = '0;
        end
      end
      irbt_pkg::RX_SAMPLE: begin
        xs.rx_timer = xs.rx_timer + 16'd1;
        if ({1'b0, xs.rx_timer} >= per) begin
          xs.rx_timer = '0;
          xs.rx_shift[xs.rx_bits] = xs.rx_shift[xs.rx_bits] | ~level;
          xs.rx_bits = xs.rx_bits + 4'd1;
          if (xs.rx_bits >= irbt_pkg::RX_BITS) begin
            rx_data    = xs.rx_shift[7:0];
            xs.rx_mode = irbt_pkg::RX_HUNT;
            if (xs.rx_shift[8] == ^rx_data && xs.rx_shift[9]) begin
              xs.rx_hold = rx_data;
              xs.rx_full = 1'b1;
            end else begin
              st.frame_error = 1'b1;
            end
          end
        end
      end
      irbt_pkg::RX_HUNT: if (!xs.rx_full && !xs.steady && xs.prev_level && !level) begin
        xs.rx_bits  = '0;
        xs.rx_shift = '0;
        xs.rx_timer = '0;
        xs.rx_mode  = (start_delay_q == 16'd0) ? irbt_pkg::RX_SAMPLE : irbt_pkg::RX_DELAY;
      end
      default: xs.rx_mode = irbt_pkg::RX_HUNT;
    endcase
    xs.prev_level = level;

    st.tx_drive       = xs.line;
    st.tx_busy        = xs.tx_active;
    st.rx_busy        = (xs.rx_mode != irbt_pkg::RX_HUNT);
    st.rx_valid       = xs.rx_full;
    st.rx_byte        = took ? taken : (xs.rx_full ? xs.rx_hold : 8'h00);
    st.carrier_sensed = ~level;
    expected_status.push_back(st);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_transceiver(in_req_type, in_tx_byte, in_rx_level);
        void'(pending_ticks.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid    <= 1'b1;
          in_req_type <= pending_ticks[0].req;
          in_tx_byte  <= pending_ticks[0].data;
          in_rx_level <= pending_ticks[0].level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_status.pop_front();
          check_field("tx_drive", 8'(want.tx_drive), 8'(out_tx_drive));
          check_field("tx_busy", 8'(want.tx_busy), 8'(out_tx_busy));
          check_field("rx_busy", 8'(want.rx_busy), 8'(out_rx_busy));
          check_field("rx_valid", 8'(want.rx_valid), 8'(out_rx_valid));
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("accepted", 8'(want.accepted), 8'(out_accepted));
          check_field("frame_error", 8'(want.frame_error), 8'(out_frame_error));
          check_field("carrier_sensed", 8'(want.carrier_sensed), 8'(out_carrier_sensed));
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen <= hold_kick;
        hold_cnt  <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (rst_n && (pending_ticks.size() != 0 || expected_status.size() != 0) &&
          !(in_valid && !in_stall) && !(out_valid && !out_stall))
        quiet++;
      else
        quiet = 0;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [2:0] random_req();
    int r;
    r = $urandom_range(99);
    if (r < 80) return irbt_pkg::REQ_TICK;
    if (r < 88) return irbt_pkg::REQ_SEND;
    if (r < 92) return irbt_pkg::REQ_TAKE;
    if (r < 94) return irbt_pkg::REQ_CARRIER_ON;
    if (r < 97) return irbt_pkg::REQ_CARRIER_OFF;
    return 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
  endfunction

  task automatic add_tick(input logic [2:0] req, input logic [7:0] data, input logic level);
    tick_t t;
    t.req   = req;
    t.data  = data;
    t.level = level;
    pending_ticks.push_back(t);
    ticks_added++;
  endtask

  // idle gap, start edge, delay, then ten bit periods; quiet frames only ask for the byte
  task automatic add_rx_frame(input logic [7:0] data, input bit bad_par, input bit bad_stop,
                              input bit quiet);
    logic [9:0] bits;
    logic [2:0] req;
    int         gap;
    bits = {~bad_stop, (^data) ^ bad_par, data};
    gap  = $urandom_range(1, 4);
    for (int i = 0; i < gap; i++) begin
      req = (quiet || (i == 0 && $urandom_range(4) != 0)) ? irbt_pkg::REQ_TAKE : random_req();
      add_tick(req, 8'($urandom), 1'b1);
    end
    for (int i = 0; i <= frame_delay; i++)
      add_tick(quiet ? irbt_pkg::REQ_TAKE : random_req(), 8'($urandom), 1'b0);
    for (int k = 0; k < 10; k++)
      for (int j = 0; j < frame_ticks; j++)
        add_tick(quiet ? irbt_pkg::REQ_TAKE : random_req(), 8'($urandom), ~bits[k]);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++)
      add_tick(random_req(), 8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic write_reg(input irbt_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      irbt_pkg::CFG_BIT_TICKS:   bit_ticks_q   = val;
      irbt_pkg::CFG_START_DELAY: start_delay_q = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] ticks, input logic [15:0] delay);
    write_reg(irbt_pkg::CFG_BIT_TICKS, ticks);
    write_reg(irbt_pkg::CFG_START_DELAY, delay);
    frame_ticks = (ticks == 16'd0) ? 1 : int'(ticks);
    frame_delay = int'(delay);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_ticks.size() != 0 || expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input logic [15:0] ticks, input logic [15:0] delay,
                            input int gap_pct, input int stall_chance, input int n,
                            input bit long_hold);
    configure(ticks, delay);
    @(negedge clk);
    send_gap_pct = gap_pct;
    stall_pct    = stall_chance;
    ticks_added  = 0;
    if (frame_ticks > 16 || frame_delay > 64) begin
      // timers far too slow for whole frames: start a frame and an edge, then noise
      add_tick(irbt_pkg::REQ_SEND, 8'($urandom), 1'b1);
      add_noise(n - 1);
    end else begin
      while (ticks_added < n) begin
        if ($urandom_range(99) < 80)
          add_rx_frame(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0, 1'b0);
        else
          add_noise($urandom_range(1, 12));
      end
    end
    if (long_hold) hold_kick = ~hold_kick;
    drain();
  endtask

  initial begin
    xs            = '{prev_level: 1'b1, rx_mode: irbt_pkg::RX_HUNT, default: '0};
    bit_ticks_q   = irbt_pkg::BIT_TICKS_RST;
    start_delay_q = irbt_pkg::START_DELAY_RST;
    frame_ticks   = 1;
    frame_delay   = 0;
    ticks_added   = 0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    errors        = 0;
    hold_kick     = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the fastest timing
    configure(16'd1, 16'd0);
    @(negedge clk);
    add_tick(irbt_pkg::REQ_TICK, 8'h00, 1'b1);
    add_tick(REQ_UNKNOWN_LAST, 8'hFF, 1'b1);
    add_tick(irbt_pkg::REQ_TAKE, 8'h00, 1'b1);
    add_tick(irbt_pkg::REQ_CARRIER_ON, 8'h00, 1'b1);
    add_tick(irbt_pkg::REQ_TICK, 8'h00, 1'b0);
    add_tick(irbt_pkg::REQ_CARRIER_OFF, 8'h00, 1'b0);
    add_tick(irbt_pkg::REQ_SEND, 8'h00, 1'b1);
    add_tick(irbt_pkg::REQ_SEND, 8'hFF, 1'b1);
    add_tick(irbt_pkg::REQ_CARRIER_ON, 8'h00, 1'b1);
    add_tick(REQ_UNKNOWN_FIRST, 8'h00, 1'b1);
    add_rx_frame(8'hA5, 1'b0, 1'b0, 1'b1);
    add_tick(irbt_pkg::REQ_TAKE, 8'h00, 1'b1);
    add_tick(irbt_pkg::REQ_SEND, 8'hFF, 1'b1);
    drain();

    run_random(16'd2, 16'd3, 0, 0, 200, 1'b0);
    run_random(16'd1, 16'd1, 68, 0, 200, 1'b0);
    run_random(16'd3, 16'd0, 0, 68, 200, 1'b1);
    run_random(16'd0, 16'd2, 28, 28, 200, 1'b0);
    run_random(16'd4, 16'd5, 0, 0, 150, 1'b0);
    run_random(16'hFFFF, 16'hFFFF, 28, 28, 40, 1'b0);
    run_random(16'd2, 16'd1, 0, 0, 60, 1'b0);

    if (errors == 0 && expected_status.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
